/* rtl/ouart_pkg.sv */
// ----------------------------------------------------------------------------
// ouart_pkg
// shared types and constants of the oversampled uart transceiver
// ----------------------------------------------------------------------------
`default_nettype none

package ouart_pkg;

    localparam int OVERSAMPLE_TICKS = 3;
    localparam int STORE_DEPTH      = 16;
    localparam int FRAME_BITS       = 10;
    localparam int DATA_BITS        = 8;

    // frame bit slots plus guard ticks, counted on the transmit slot counter
    localparam int GUARD_LIMIT = FRAME_BITS + 5 * OVERSAMPLE_TICKS;

    localparam int TX_BITS_W = $clog2(GUARD_LIMIT + 2);
    localparam int TX_TICK_W = $clog2(OVERSAMPLE_TICKS + 1);
    localparam int RX_TICK_W = $clog2(OVERSAMPLE_TICKS + 2);
    localparam int RX_BITS_W = $clog2(DATA_BITS + 1);
    localparam int PTR_W     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam int RX_RESTART_TICK = 2;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_HALF_DUPLEX = PADDR_W'(0);

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_LISTEN = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       rx_line;
        logic [7:0] tx_byte;
    } in_item_t;

    typedef struct packed {
        logic       tx_line;
        logic       line_driven;
        logic       write_accepted;
        logic       read_valid;
        logic [7:0] read_data;
        logic       tx_busy;
        logic       rx_listening;
    } out_item_t;

    // transmitter requests to the receiver
    typedef struct packed {
        logic restart_rx;
        logic stop_rx;
    } tx_ctl_t;

    // transmitter view after the current item
    typedef struct packed {
        logic line_level;
        logic line_is_output;
        logic running;
        logic accepted;
    } tx_res_t;

    // receiver view after the current item
    typedef struct packed {
        logic       running;
        logic       read_valid;
        logic [7:0] read_data;
    } rx_res_t;

endpackage

`default_nettype wire

/* rtl/ouart_tx.sv */
// ----------------------------------------------------------------------------
// ouart_tx
// transmit shifter, bit and tick counters, guard period and line control
// ----------------------------------------------------------------------------
`default_nettype none

module ouart_tx
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire ouart_pkg::in_item_t item,
    input  wire logic                half_duplex,
    input  wire logic                rx_running,
    output ouart_pkg::tx_ctl_t       ctl,
    output ouart_pkg::tx_res_t       res
);

    logic [ouart_pkg::FRAME_BITS-1:0] shift_reg, shift_next;
    logic [ouart_pkg::TX_BITS_W-1:0]  bits_reg, bits_next;
    logic [ouart_pkg::TX_TICK_W-1:0]  tick_reg, tick_next;
    logic                             running_reg, running_next;
    logic                             level_reg, level_next;
    logic                             drive_reg, drive_next;
    logic                             accepted;

    always_comb
    begin
        shift_next   = shift_reg;
        bits_next    = bits_reg;
        tick_next    = tick_reg;
        running_next = running_reg;
        level_next   = level_reg;
        drive_next   = drive_reg;
        accepted     = 1'b0;
        ctl          = '0;
        case (item.op)
            ouart_pkg::OP_TICK:
            begin
                if (running_reg)
                begin
                    if (tick_reg > ouart_pkg::TX_TICK_W'(1))
                    begin
                        tick_next = tick_reg - ouart_pkg::TX_TICK_W'(1);
                    end
                    else if (bits_reg < ouart_pkg::TX_BITS_W'(ouart_pkg::FRAME_BITS))
                    begin
                        bits_next  = bits_reg + ouart_pkg::TX_BITS_W'(1);
                        level_next = shift_reg[0];
                        shift_next = shift_reg >> 1;
                        tick_next  = ouart_pkg::TX_TICK_W'(ouart_pkg::OVERSAMPLE_TICKS);
                    end
                    else
                    begin
                        // guard period
                        bits_next = bits_reg + ouart_pkg::TX_BITS_W'(1);
                        tick_next = ouart_pkg::TX_TICK_W'(1);
                        if (bits_reg >= ouart_pkg::TX_BITS_W'(ouart_pkg::GUARD_LIMIT))
                        begin
                            running_next = 1'b0;
                            if (half_duplex)
                            begin
                                drive_next     = 1'b0;
                                ctl.restart_rx = 1'b1;
                            end
                        end
                    end
                end
            end
            ouart_pkg::OP_WRITE:
            begin
                if (!running_reg)
                begin
                    shift_next = {1'b1, item.tx_byte, 1'b0};
                    bits_next  = '0;
                    tick_next  = ouart_pkg::TX_TICK_W'(ouart_pkg::OVERSAMPLE_TICKS);
                    if (half_duplex && rx_running)
                    begin
                        drive_next  = 1'b1;
                        level_next  = 1'b1;
                        ctl.stop_rx = 1'b1;
                    end
                    running_next = 1'b1;
                    accepted     = 1'b1;
                end
            end
            ouart_pkg::OP_LISTEN:
            begin
                if (half_duplex)
                begin
                    drive_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        if (!fire)
        begin
            ctl = '0;
        end
        res.line_level     = level_next;
        res.line_is_output = drive_next;
        res.running        = running_next;
        res.accepted       = accepted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg   <= '1;
            bits_reg    <= '0;
            tick_reg    <= '0;
            running_reg <= 1'b0;
            level_reg   <= 1'b1;
            drive_reg   <= 1'b1;
        end
        else if (fire)
        begin
            shift_reg   <= shift_next;
            bits_reg    <= bits_next;
            tick_reg    <= tick_next;
            running_reg <= running_next;
            level_reg   <= level_next;
            drive_reg   <= drive_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/ouart_rx.sv */
// ----------------------------------------------------------------------------
// ouart_rx
// receive sampler, start hunt, byte assembly and the ring store
// ----------------------------------------------------------------------------
`default_nettype none

module ouart_rx
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire ouart_pkg::in_item_t item,
    input  wire ouart_pkg::tx_ctl_t  ctl,
    output logic                     running,
    output ouart_pkg::rx_res_t       res
);

    logic [7:0]                      shift_reg, shift_next;
    logic [ouart_pkg::RX_BITS_W-1:0] bits_reg, bits_next;
    logic                            hunting_reg, hunting_next;
    logic [ouart_pkg::RX_TICK_W-1:0] tick_reg, tick_next;
    logic                            running_reg, running_next;
    logic [ouart_pkg::PTR_W-1:0]     wi_reg, wi_next;
    logic [ouart_pkg::PTR_W-1:0]     ri_reg, ri_next;
    logic                            we;
    logic                            pop;
    logic [7:0]                      head_reg;
    logic [7:0]                      store_mem [ouart_pkg::STORE_DEPTH];

    function automatic logic [ouart_pkg::PTR_W-1:0] ptr_inc(
        input logic [ouart_pkg::PTR_W-1:0] p
    );
        if (p == ouart_pkg::PTR_W'(ouart_pkg::STORE_DEPTH - 1))
        begin
            return '0;
        end
        return p + ouart_pkg::PTR_W'(1);
    endfunction

    always_comb
    begin
        shift_next   = shift_reg;
        bits_next    = bits_reg;
        hunting_next = hunting_reg;
        tick_next    = tick_reg;
        running_next = running_reg;
        wi_next      = wi_reg;
        ri_next      = ri_reg;
        we           = 1'b0;
        pop          = 1'b0;
        // restart after the transmit guard, applied before sampling
        if (ctl.restart_rx)
        begin
            hunting_next = 1'b1;
            bits_next    = '0;
            tick_next    = ouart_pkg::RX_TICK_W'(ouart_pkg::RX_RESTART_TICK);
            running_next = 1'b1;
        end
        case (item.op)
            ouart_pkg::OP_TICK:
            begin
                if (running_next)
                begin
                    if (tick_next > ouart_pkg::RX_TICK_W'(1))
                    begin
                        tick_next = tick_next - ouart_pkg::RX_TICK_W'(1);
                    end
                    else if (hunting_next)
                    begin
                        if (!item.rx_line)
                        begin
                            hunting_next = 1'b0;
                            bits_next    = '0;
                            tick_next    = ouart_pkg::RX_TICK_W'(ouart_pkg::OVERSAMPLE_TICKS + 1);
                            shift_next   = '0;
                        end
                        else
                        begin
                            tick_next = ouart_pkg::RX_TICK_W'(1);
                        end
                    end
                    else if (bits_next >= ouart_pkg::RX_BITS_W'(ouart_pkg::DATA_BITS))
                    begin
                        we           = 1'b1;
                        wi_next      = ptr_inc(wi_reg);
                        tick_next    = ouart_pkg::RX_TICK_W'(1);
                        hunting_next = 1'b1;
                        bits_next    = '0;
                    end
                    else
                    begin
                        shift_next = {item.rx_line, shift_reg[7:1]};
                        bits_next  = bits_next + ouart_pkg::RX_BITS_W'(1);
                        tick_next  = ouart_pkg::RX_TICK_W'(ouart_pkg::OVERSAMPLE_TICKS);
                    end
                end
            end
            ouart_pkg::OP_WRITE:
            begin
                if (ctl.stop_rx)
                begin
                    running_next = 1'b0;
                end
            end
            ouart_pkg::OP_READ:
            begin
                if (ri_reg != wi_reg)
                begin
                    pop     = 1'b1;
                    ri_next = ptr_inc(ri_reg);
                end
            end
            ouart_pkg::OP_LISTEN:
            begin
                hunting_next = 1'b1;
                bits_next    = '0;
                tick_next    = ouart_pkg::RX_TICK_W'(ouart_pkg::RX_RESTART_TICK);
                running_next = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (!fire)
        begin
            we      = 1'b0;
            pop     = 1'b0;
            ri_next = ri_reg;
        end
        res.running    = running_next;
        res.read_valid = pop;
        res.read_data  = pop ? head_reg : 8'h00;
    end

    assign running = running_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg   <= '0;
            bits_reg    <= '0;
            hunting_reg <= 1'b1;
            tick_reg    <= ouart_pkg::RX_TICK_W'(ouart_pkg::RX_RESTART_TICK);
            running_reg <= 1'b0;
            wi_reg      <= '0;
            ri_reg      <= '0;
        end
        else if (fire)
        begin
            shift_reg   <= shift_next;
            bits_reg    <= bits_next;
            hunting_reg <= hunting_next;
            tick_reg    <= tick_next;
            running_reg <= running_next;
            wi_reg      <= wi_next;
            ri_reg      <= ri_next;
        end
    end

    // store with a read-ahead head register, bypassed on a write to the head
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[wi_reg] <= shift_reg;
        end
        if (we && (wi_reg == ri_next))
        begin
            head_reg <= shift_reg;
        end
        else
        begin
            head_reg <= store_mem[ri_next];
        end
    end

endmodule

`default_nettype wire

/* rtl/ouart_outbuf.sv */
// ----------------------------------------------------------------------------
// ouart_outbuf
// result register with a skid entry behind it
// ----------------------------------------------------------------------------
`default_nettype none

module ouart_outbuf
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire ouart_pkg::out_item_t load_data,
    output logic                      full,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output ouart_pkg::out_item_t      out_data
);

    logic                 out_valid_reg, out_valid_next;
    ouart_pkg::out_item_t out_data_reg, out_data_next;
    logic                 skid_valid_reg, skid_valid_next;
    ouart_pkg::out_item_t skid_data_reg, skid_data_next;
    logic                 advance;

    always_comb
    begin
        advance         = !out_valid_reg || !out_stall;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (advance)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = load;
                out_data_next  = load_data;
            end
        end
        else if (load)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = load_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

/* rtl/oversampled_uart_transceiver.sv */
// ----------------------------------------------------------------------------
// oversampled_uart_transceiver
// uart 8n1 engine stepped by oversample ticks, with a receive ring store
//
// usage
//   in channel: in_valid / in_stall / in_data, one op per item: tick, write
//   byte, read byte or listen. out channel: out_valid / out_stall / out_data,
//   exactly one result item per input item, in order.
//   one item is taken every cycle while in_stall is low. all work for an item
//   is done in the cycle it is accepted and lands in the result register, or
//   in the skid entry behind it while a result waits; the skid entry keeps
//   the input open for one more item, so in_stall rises only when both hold
//   a result.
//   the receive store reads ahead into a head register, so a read op returns
//   its byte in its own result item. reset leaves the transmitter idle with
//   the line high and driven, the receiver off, the store empty and half
//   duplex off; no clearing pass. the user writes half_duplex over the apb
//   port only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module oversampled_uart_transceiver
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire ouart_pkg::in_item_t               in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output ouart_pkg::out_item_t                   out_data,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ouart_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [ouart_pkg::PDATA_W-1:0]     pwdata,
    output logic [ouart_pkg::PDATA_W-1:0]          prdata,
    output logic                                   pready
);

    logic                 half_duplex_reg;
    logic                 fire;
    logic                 buf_full;
    logic                 rx_running;
    ouart_pkg::tx_ctl_t   tx_ctl;
    ouart_pkg::tx_res_t   tx_res;
    ouart_pkg::rx_res_t   rx_res;
    ouart_pkg::out_item_t result;

    assign pready   = 1'b1;
    assign in_stall = buf_full;
    assign fire     = in_valid && !buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_duplex_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && (paddr == ouart_pkg::ADDR_HALF_DUPLEX))
        begin
            half_duplex_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr == ouart_pkg::ADDR_HALF_DUPLEX)
                  ? {{(ouart_pkg::PDATA_W-1){1'b0}}, half_duplex_reg}
                  : '0;

    ouart_tx u_tx
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (in_data),
        .half_duplex (half_duplex_reg),
        .rx_running  (rx_running),
        .ctl         (tx_ctl),
        .res         (tx_res)
    );

    ouart_rx u_rx
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (in_data),
        .ctl     (tx_ctl),
        .running (rx_running),
        .res     (rx_res)
    );

    always_comb
    begin
        result.tx_line        = tx_res.line_level;
        result.line_driven    = half_duplex_reg ? tx_res.line_is_output : 1'b1;
        result.write_accepted = tx_res.accepted;
        result.read_valid     = rx_res.read_valid;
        result.read_data      = rx_res.read_data;
        result.tx_busy        = tx_res.running;
        result.rx_listening   = rx_res.running;
    end

    ouart_outbuf u_outbuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .load_data (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // skid entry only fills behind a waiting result
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result waiting");

    // after an accepted item, out_valid is always high in the next cycle
    a_one_cycle_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted item produced no result");

    a_write_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.write_accepted) |-> out_data.tx_busy)
        else $error("write accepted but transmitter idle");

    a_empty_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.read_valid) |-> (out_data.read_data == 8'h00))
        else $error("read data nonzero without a popped byte");

    a_full_duplex_drives: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !half_duplex_reg) |-> out_data.line_driven)
        else $error("line released in full duplex");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the oversampled uart transceiver: a queue-fed
// driver offers op items and mirrors every accepted item in a cycle model of
// the transmitter, receiver and receive ring; a monitor checks each status
// item against that model, with random idling, a long receiver hold-off and
// changes of duplex mode between phases
// ----------------------------------------------------------------------------

module testbench;

    localparam int HOLD_CYCLES   = 40;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 10;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    ouart_pkg::in_item_t            in_data   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    ouart_pkg::out_item_t           out_data;
    logic                           psel      = 1'b0;
    logic                           penable   = 1'b0;
    logic                           pwrite    = 1'b0;
    logic [ouart_pkg::PADDR_W-1:0]  paddr     = '0;
    logic [ouart_pkg::PDATA_W-1:0]  pwdata    = '0;
    logic [ouart_pkg::PDATA_W-1:0]  prdata;
    logic                           pready;

    ouart_pkg::in_item_t  ops_to_send[$];
    ouart_pkg::out_item_t status_due[$];
    int        n_queued    = 0;
    int        mismatches  = 0;
    int        idle_pct    = 30;
    int        hold_req    = 0;
    int        hold_done   = 0;
    int        hold_left   = 0;
    int        quiet       = 0;

    // cycle model of the transceiver
    logic                             hd_mode;
    logic [ouart_pkg::FRAME_BITS-1:0] tx_sr;
    logic [ouart_pkg::TX_BITS_W-1:0]  tx_slots;
    logic [ouart_pkg::TX_TICK_W-1:0]  tx_cnt;
    logic                             tx_on;
    logic [7:0]                       rx_sr;
    logic [ouart_pkg::RX_BITS_W-1:0]  rx_nbits;
    logic                             rx_seek;
    logic [ouart_pkg::RX_TICK_W-1:0]  rx_cnt;
    logic                             rx_on;
    logic [7:0]                       rx_ring [ouart_pkg::STORE_DEPTH];
    logic [ouart_pkg::PTR_W-1:0]      ring_wr;
    logic [ouart_pkg::PTR_W-1:0]      ring_rd;
    logic                             line_lvl;
    logic                             line_out;

    oversampled_uart_transceiver i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void clear_model();
        hd_mode  = 1'b0;
        tx_sr    = '1;
        tx_slots = '0;
        tx_cnt   = '0;
        tx_on    = 1'b0;
        rx_sr    = '0;
        rx_nbits = '0;
        rx_seek  = 1'b1;
        rx_cnt   = ouart_pkg::RX_TICK_W'(ouart_pkg::RX_RESTART_TICK);
        rx_on    = 1'b0;
        for (int i = 0; i < ouart_pkg::STORE_DEPTH; i++)
        begin
            rx_ring[i] = '0;
        end
        ring_wr  = '0;
        ring_rd  = '0;
        line_lvl = 1'b1;
        line_out = 1'b1;
    endfunction

    function automatic void rx_restart();
        if (hd_mode)
        begin
            line_out = 1'b0;
        end
        rx_seek  = 1'b1;
        rx_nbits = '0;
        rx_cnt   = ouart_pkg::RX_TICK_W'(ouart_pkg::RX_RESTART_TICK);
        rx_on    = 1'b1;
    endfunction

    function automatic void tx_tick();
        if (tx_cnt > ouart_pkg::TX_TICK_W'(1))
        begin
            tx_cnt = tx_cnt - ouart_pkg::TX_TICK_W'(1);
        end
        else if (tx_slots < ouart_pkg::TX_BITS_W'(ouart_pkg::FRAME_BITS))
        begin
            tx_slots = tx_slots + ouart_pkg::TX_BITS_W'(1);
            line_lvl = tx_sr[0];
            tx_sr    = tx_sr >> 1;
            tx_cnt   = ouart_pkg::TX_TICK_W'(ouart_pkg::OVERSAMPLE_TICKS);
        end
        else
        begin
            if (tx_slots != '1)
            begin
                tx_slots = tx_slots + ouart_pkg::TX_BITS_W'(1);
            end
            tx_cnt = ouart_pkg::TX_TICK_W'(1);
            if (tx_slots > ouart_pkg::TX_BITS_W'(ouart_pkg::GUARD_LIMIT))
            begin
                if (hd_mode)
                begin
                    rx_restart();
                end
                tx_on = 1'b0;
            end
        end
    endfunction

    function automatic void rx_tick(input logic level);
        if (rx_cnt > ouart_pkg::RX_TICK_W'(1))
        begin
            rx_cnt = rx_cnt - ouart_pkg::RX_TICK_W'(1);
        end
        else if (rx_seek)
        begin
            if (!level)
            begin
                rx_seek  = 1'b0;
                rx_nbits = '0;
                rx_cnt   = ouart_pkg::RX_TICK_W'(ouart_pkg::OVERSAMPLE_TICKS + 1);
                rx_sr    = '0;
            end
            else
            begin
                rx_cnt = ouart_pkg::RX_TICK_W'(1);
            end
        end
        else if (rx_nbits >= ouart_pkg::RX_BITS_W'(ouart_pkg::DATA_BITS))
        begin
            rx_ring[ring_wr] = rx_sr;
            ring_wr  = ring_wr + ouart_pkg::PTR_W'(1);
            rx_cnt   = ouart_pkg::RX_TICK_W'(1);
            rx_seek  = 1'b1;
            rx_nbits = '0;
        end
        else
        begin
            rx_sr    = {level, rx_sr[7:1]};
            rx_nbits = rx_nbits + ouart_pkg::RX_BITS_W'(1);
            rx_cnt   = ouart_pkg::RX_TICK_W'(ouart_pkg::OVERSAMPLE_TICKS);
        end
    endfunction

    function automatic ouart_pkg::out_item_t uart_step(input ouart_pkg::in_item_t item);
        ouart_pkg::out_item_t st;
        st = '0;
        case (item.op)
            ouart_pkg::OP_TICK:
            begin
                if (tx_on)
                begin
                    tx_tick();
                end
                if (rx_on)
                begin
                    rx_tick(item.rx_line);
                end
            end
            ouart_pkg::OP_WRITE:
            begin
                if (!tx_on)
                begin
                    tx_sr    = {1'b1, item.tx_byte, 1'b0};
                    tx_slots = '0;
                    tx_cnt   = ouart_pkg::TX_TICK_W'(ouart_pkg::OVERSAMPLE_TICKS);
                    if (hd_mode && rx_on)
                    begin
                        line_out = 1'b1;
                        line_lvl = 1'b1;
                        rx_on    = 1'b0;
                    end
                    tx_on             = 1'b1;
                    st.write_accepted = 1'b1;
                end
            end
            ouart_pkg::OP_READ:
            begin
                if (ring_rd != ring_wr)
                begin
                    st.read_data  = rx_ring[ring_rd];
                    st.read_valid = 1'b1;
                    ring_rd       = ring_rd + ouart_pkg::PTR_W'(1);
                end
            end
            default:
            begin
                rx_restart();
            end
        endcase
        st.tx_line      = line_lvl;
        st.line_driven  = hd_mode ? line_out : 1'b1;
        st.tx_busy      = tx_on;
        st.rx_listening = rx_on;
        return st;
    endfunction

    function automatic void match_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                status_due.push_back(uart_step(in_data));
            end
            if (!in_valid || !in_stall)
            begin
                if (ops_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    in_data  <= ops_to_send.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : status_monitor
        ouart_pkg::out_item_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (status_due.size() == 0)
                begin
                    $error("status item with nothing pending: %h", out_data);
                    mismatches++;
                end
                else
                begin
                    want = status_due.pop_front();
                    match_field("tx_line", 8'(want.tx_line), 8'(out_data.tx_line));
                    match_field("line_driven", 8'(want.line_driven),
                                8'(out_data.line_driven));
                    match_field("write_accepted", 8'(want.write_accepted),
                                8'(out_data.write_accepted));
                    match_field("read_valid", 8'(want.read_valid),
                                8'(out_data.read_valid));
                    match_field("read_data", want.read_data, out_data.read_data);
                    match_field("tx_busy", 8'(want.tx_busy), 8'(out_data.tx_busy));
                    match_field("rx_listening", 8'(want.rx_listening),
                                8'(out_data.rx_listening));
                end
            end
            if (hold_req != hold_done)
            begin
                hold_done <= hold_req;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet <= 0;
        end
        else
        begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic set_half_duplex(input logic val);
        logic [ouart_pkg::PDATA_W-1:0] got;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ouart_pkg::ADDR_HALF_DUPLEX;
        pwdata  <= ouart_pkg::PDATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        hd_mode = val;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== ouart_pkg::PDATA_W'(val))
        begin
            $error("half_duplex readback: expected %0h, got %0h",
                   ouart_pkg::PDATA_W'(val), got);
            mismatches++;
        end
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (ops_to_send.size() != 0 || in_valid || status_due.size() != 0);
    endtask

    task automatic push_op(input ouart_pkg::op_t op, input logic level,
                           input logic [7:0] data);
        ouart_pkg::in_item_t item;
        item.op      = op;
        item.rx_line = level;
        item.tx_byte = data;
        ops_to_send.push_back(item);
        n_queued++;
    endtask

    task automatic push_ticks(input int count, input logic level);
        repeat (count)
        begin
            push_op(ouart_pkg::OP_TICK, level, 8'($urandom));
        end
    endtask

    // one 8n1 frame on the receive line, optionally with other ops mixed in
    task automatic push_rx_frame(input logic [7:0] data, input int lead, input bit noisy);
        logic lvl;
        push_ticks(lead, 1'b1);
        for (int slot = 0; slot < ouart_pkg::FRAME_BITS; slot++)
        begin
            lvl = (slot == 0) ? 1'b0
                : (slot == ouart_pkg::FRAME_BITS - 1) ? 1'b1 : data[slot - 1];
            for (int k = 0; k < ouart_pkg::OVERSAMPLE_TICKS; k++)
            begin
                if (noisy && $urandom_range(0, 99) < 4)
                begin
                    push_op($urandom_range(0, 1) ? ouart_pkg::OP_WRITE : ouart_pkg::OP_READ,
                            1'($urandom), 8'($urandom));
                end
                push_op(ouart_pkg::OP_TICK, lvl, 8'($urandom));
            end
        end
    endtask

    task automatic fill_traffic(input int count, input int read_pct);
        int stop_at;
        int roll;
        stop_at = n_queued + count;
        while (n_queued < stop_at)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
            begin
                push_rx_frame(8'($urandom), $urandom_range(0, 3), 1'b1);
            end
            else if (roll < 50 + read_pct)
            begin
                push_op(ouart_pkg::OP_READ, 1'($urandom), 8'($urandom));
            end
            else if (roll < 75)
            begin
                push_op(ouart_pkg::OP_WRITE, 1'($urandom), 8'($urandom));
            end
            else if (roll < 80)
            begin
                push_op(ouart_pkg::OP_LISTEN, 1'($urandom), 8'($urandom));
            end
            else if (roll < 90)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    push_op(ouart_pkg::OP_TICK, 1'($urandom), 8'($urandom));
                end
            end
            else
            begin
                // start bit followed by garbage
                push_ticks(ouart_pkg::OVERSAMPLE_TICKS, 1'b0);
                repeat ($urandom_range(1, 20))
                begin
                    push_op(ouart_pkg::OP_TICK, 1'($urandom), 8'($urandom));
                end
            end
        end
    endtask

    initial
    begin
        clear_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // full duplex: empty read, busy write, loopback-free receive
        set_half_duplex(1'b0);
        push_op(ouart_pkg::OP_READ, 1'b1, 8'h00);
        push_op(ouart_pkg::OP_WRITE, 1'b0, 8'h00);
        push_op(ouart_pkg::OP_WRITE, 1'b1, 8'hFF);
        push_op(ouart_pkg::OP_LISTEN, 1'b0, 8'hFF);
        push_rx_frame(8'h80, 1, 1'b0);
        push_ticks(20, 1'b1);
        push_op(ouart_pkg::OP_READ, 1'b0, 8'h00);
        push_op(ouart_pkg::OP_READ, 1'b1, 8'hFF);
        wait_drained();

        // half duplex: release, turnaround on write, guard end restarts receiver
        set_half_duplex(1'b1);
        push_op(ouart_pkg::OP_LISTEN, 1'b1, 8'h00);
        push_op(ouart_pkg::OP_WRITE, 1'b0, 8'h5A);
        push_op(ouart_pkg::OP_WRITE, 1'b0, 8'hA5);
        push_ticks(50, 1'b1);
        push_rx_frame(8'h01, 1, 1'b0);
        push_rx_frame(8'hFE, 0, 1'b0);
        repeat (3)
        begin
            push_op(ouart_pkg::OP_READ, 1'b0, 8'h00);
        end
        wait_drained();

        set_half_duplex(1'b0);
        fill_traffic(20, 15);
        wait_drained();

        // no idling, plus a long receiver hold-off while items keep coming
        set_half_duplex(1'b1);
        idle_pct = 0;
        fill_traffic(40, 15);
        hold_req++;
        wait_drained();
        idle_pct = 30;

        // ring wrap: a full store of bytes without reads looks empty
        set_half_duplex(1'b0);
        repeat (ouart_pkg::STORE_DEPTH + 4)
        begin
            push_op(ouart_pkg::OP_READ, 1'($urandom), 8'($urandom));
        end
        push_op(ouart_pkg::OP_LISTEN, 1'b1, 8'($urandom));
        repeat (ouart_pkg::STORE_DEPTH)
        begin
            push_rx_frame(8'($urandom), $urandom_range(0, 2), 1'b0);
        end
        push_op(ouart_pkg::OP_READ, 1'b1, 8'($urandom));
        push_rx_frame(8'($urandom), 1, 1'b0);
        push_op(ouart_pkg::OP_READ, 1'b1, 8'($urandom));
        push_op(ouart_pkg::OP_READ, 1'b0, 8'($urandom));
        wait_drained();

        set_half_duplex(1'b1);
        fill_traffic(20, 10);
        wait_drained();

        set_half_duplex(1'b0);
        fill_traffic(20, 15);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && status_due.size() == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/ouart_pkg.sv
rtl/ouart_tx.sv
rtl/ouart_rx.sv
rtl/ouart_outbuf.sv
rtl/oversampled_uart_transceiver.sv
tb/testbench.sv
